FILE: hdl/wrsp_pkg.sv
// shared types and constants for the riff wave stream parser
// used by wrsp_div, wrsp_parse and wav_riff_stream_parser_top; no dependencies
package wrsp_pkg;

  // byte counter width default
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // shared divider sizes
  localparam int unsigned DVD_W = 32;
  localparam int unsigned DVS_W = 16;

  // chunk tags, little-endian as they arrive
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // pcm format tag
  localparam logic [15:0] FMT_PCM = 16'd1;

  // error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_HEADER  = 2'd1;
  localparam logic [1:0] ERR_NO_FMT  = 2'd2;
  localparam logic [1:0] ERR_NO_SMP  = 2'd3;

  // result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // sample word made from a pair of data bytes
  typedef struct packed {
    logic        valid;
    logic [15:0] value;
    logic [29:0] index;
  } smp_t;

  // end-of-file snapshot taken with the final byte
  typedef struct packed {
    logic [1:0]  err;
    logic [15:0] ch;
    logic [31:0] rate;
    logic [15:0] bps;
    logic [31:0] dlen;
  } stat_t;

endpackage

FILE: hdl/wrsp_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on wrsp_pkg for operand widths
module wrsp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [wrsp_pkg::DVD_W-1:0] dividend,
  input  logic [wrsp_pkg::DVS_W-1:0] divisor,
  output logic                      done,
  output logic [wrsp_pkg::DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(wrsp_pkg::DVD_W + 1);

  logic [CNT_W-1:0]            cnt;
  logic                        busy;
  logic [wrsp_pkg::DVS_W-1:0]  rem;
  logic [wrsp_pkg::DVD_W-1:0]  quo;
  logic [wrsp_pkg::DVS_W-1:0]  dvs;
  logic [wrsp_pkg::DVS_W:0]    rem_sh;
  logic [wrsp_pkg::DVS_W:0]    rem_sub;
  logic                        fits;

  // one trial subtract per cycle
  assign rem_sh  = {rem, quo[wrsp_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign fits    = (rem_sh >= {1'b0, dvs});

  assign quotient = quo;

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(wrsp_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub[wrsp_pkg::DVS_W-1:0] : rem_sh[wrsp_pkg::DVS_W-1:0];
      quo <= {quo[wrsp_pkg::DVD_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/wrsp_parse.sv
// byte-level riff wave parser: header check, chunk walk, fmt and data capture
// depends on wrsp_pkg for tags, codes and the result structs
module wrsp_parse #(
  parameter int unsigned COUNT_WIDTH = wrsp_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            final_byte,
  output wrsp_pkg::smp_t  smp,
  output wrsp_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_SIZE = 3'd1,
    PH_WAVE = 3'd2,
    PH_ID   = 3'd3,
    PH_LEN  = 3'd4,
    PH_BODY = 3'd5,
    PH_PAD  = 3'd6
  } phase_t;

  phase_t                 phase, phase_next;
  logic [1:0]             bif, bif_next;
  logic [COUNT_WIDTH-1:0] total, total_next;
  logic [31:0]            declared, declared_next;
  logic                   hdr_good, hdr_good_next;
  logic [31:0]            tag, tag_next;
  logic [31:0]            left, left_next;
  logic [31:0]            clen, clen_next;
  logic [63:0]            fmt, fmt_next;
  logic                   fmt_ok, fmt_ok_next;
  logic [31:0]            dlen, dlen_next;
  logic [7:0]             low_hold, low_hold_next;
  logic [29:0]            wc, wc_next;

  logic [31:0] byte_sh;
  logic        last;
  logic [31:0] off;
  logic        size_ok;
  logic        hdr_ok;

  assign byte_sh = {24'd0, data_byte} << {bif, 3'b000};
  assign last    = (bif == 2'd3);
  assign off     = clen - left;

  // next parser state for the byte on the input
  always_comb begin
    phase_next    = phase;
    bif_next      = bif;
    total_next    = total + 1'b1;
    declared_next = declared;
    hdr_good_next = hdr_good;
    tag_next      = tag;
    left_next     = left;
    clen_next     = clen;
    fmt_next      = fmt;
    fmt_ok_next   = fmt_ok;
    dlen_next     = dlen;
    low_hold_next = low_hold;
    wc_next       = wc;
    smp.valid     = 1'b0;
    smp.value     = {data_byte, low_hold};
    smp.index     = wc;

    unique case (phase)
      PH_RIFF, PH_WAVE, PH_ID: begin
        tag_next = ((bif == 2'd0) ? 32'd0 : tag) | byte_sh;
        bif_next = bif + 1'b1;
        if (last) begin
          if (phase == PH_RIFF) begin
            if (tag_next != wrsp_pkg::TAG_RIFF) hdr_good_next = 1'b0;
            phase_next = PH_SIZE;
          end else if (phase == PH_WAVE) begin
            if (tag_next != wrsp_pkg::TAG_WAVE) hdr_good_next = 1'b0;
            phase_next = PH_ID;
          end else begin
            phase_next = PH_LEN;
          end
        end
      end
      PH_SIZE: begin
        declared_next = ((bif == 2'd0) ? 32'd0 : declared) | byte_sh;
        bif_next      = bif + 1'b1;
        if (last) phase_next = PH_WAVE;
      end
      PH_LEN: begin
        clen_next = ((bif == 2'd0) ? 32'd0 : clen) | byte_sh;
        bif_next  = bif + 1'b1;
        if (last) begin
          left_next = clen_next;
          if (tag == wrsp_pkg::TAG_FMT) fmt_next = '0;
          if (tag == wrsp_pkg::TAG_DATA) begin
            dlen_next = clen_next;
            wc_next   = '0;
          end
          phase_next = (clen_next == 32'd0) ? PH_ID : PH_BODY;
        end
      end
      PH_BODY: begin
        // fmt fields land in the packed fmt word
        if (tag == wrsp_pkg::TAG_FMT) begin
          if (off < 32'd16) begin
            case (off[3:0])
              4'd0:  fmt_next[55:48] = fmt[55:48] | data_byte;
              4'd1:  fmt_next[63:56] = fmt[63:56] | data_byte;
              4'd2:  fmt_next[7:0]   = fmt[7:0]   | data_byte;
              4'd3: begin
                fmt_next[15:8] = fmt[15:8] | data_byte;
                if (fmt_next[63:48] == wrsp_pkg::FMT_PCM &&
                    (fmt_next[15:0] == 16'd1 || fmt_next[15:0] == 16'd2))
                  fmt_ok_next = 1'b1;
                fmt_next[63:48] = 16'd0;
              end
              4'd4:  fmt_next[23:16] = fmt[23:16] | data_byte;
              4'd5:  fmt_next[31:24] = fmt[31:24] | data_byte;
              4'd6:  fmt_next[39:32] = fmt[39:32] | data_byte;
              4'd7:  fmt_next[47:40] = fmt[47:40] | data_byte;
              4'd14: fmt_next[55:48] = fmt[55:48] | data_byte;
              4'd15: fmt_next[63:56] = fmt[63:56] | data_byte;
              default: ;
            endcase
          end
        end else if (tag == wrsp_pkg::TAG_DATA) begin
          // pair bytes into little-endian words
          if (!off[0]) begin
            low_hold_next = data_byte;
          end else begin
            smp.valid = 1'b1;
            wc_next   = wc + 1'b1;
          end
        end
        left_next = left - 1'b1;
        if (left_next == 32'd0) begin
          phase_next = clen[0] ? PH_PAD : PH_ID;
          bif_next   = 2'd0;
        end
      end
      // pad byte after an odd chunk
      default: begin
        phase_next = PH_ID;
        bif_next   = 2'd0;
      end
    endcase
  end

  // end-of-file checks on the updated state
  assign size_ok = ((declared_next >> COUNT_WIDTH) == 32'd0) &&
                   (declared_next[COUNT_WIDTH-1:0] == total_next - COUNT_WIDTH'(8));
  assign hdr_ok  = hdr_good_next && size_ok &&
                   phase_next != PH_RIFF && phase_next != PH_SIZE && phase_next != PH_WAVE;

  always_comb begin
    if (!hdr_ok)                stat.err = wrsp_pkg::ERR_HEADER;
    else if (!fmt_ok_next)      stat.err = wrsp_pkg::ERR_NO_FMT;
    else if (dlen_next == 32'd0) stat.err = wrsp_pkg::ERR_NO_SMP;
    else                        stat.err = wrsp_pkg::ERR_OK;
    stat.ch   = fmt_next[15:0];
    stat.rate = fmt_next[47:16];
    stat.bps  = fmt_next[63:48];
    stat.dlen = dlen_next;
  end

  // state registers, cleared again after the final byte
  always_ff @(posedge clk) begin
    if (rst || (take && final_byte)) begin
      phase    <= PH_RIFF;
      bif      <= '0;
      total    <= '0;
      declared <= '0;
      hdr_good <= 1'b1;
      tag      <= '0;
      left     <= '0;
      clen     <= '0;
      fmt      <= '0;
      fmt_ok   <= 1'b0;
      dlen     <= '0;
      low_hold <= '0;
      wc       <= '0;
    end else if (take) begin
      phase    <= phase_next;
      bif      <= bif_next;
      total    <= total_next;
      declared <= declared_next;
      hdr_good <= hdr_good_next;
      tag      <= tag_next;
      left     <= left_next;
      clen     <= clen_next;
      fmt      <= fmt_next;
      fmt_ok   <= fmt_ok_next;
      dlen     <= dlen_next;
      low_hold <= low_hold_next;
      wc       <= wc_next;
    end
  end

endmodule

FILE: hdl/wav_riff_stream_parser_top.sv
// riff wave stream parser top: parser, shared divider, status sequencer, output register
// depends on wrsp_pkg, wrsp_parse and wrsp_div
//
//  channel  dir  handshake             payload
//  s_*      in   s_tvalid / s_tready   s_tdata = data_byte, s_tlast = final_byte
//  m_*      out  m_tvalid / m_tready   m_tdata = result fields, m_tuser = kind,
//                                      m_tlast = end_mark
//
// an ordinary byte is taken while s_tready is high; a data word goes to the output
// register at the same edge. the final byte adds two passes of the shared 32-step
// divider (bytes per sample, then channels): the status item is loaded after the
// second pass, or directly when no division is needed, and s_tready stays low
// meanwhile and whenever the output register is full and not being taken. rst is
// synchronous and clears all parser state.
module wav_riff_stream_parser_top #(
  parameter int unsigned COUNT_WIDTH = wrsp_pkg::COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] sample_value, [45:16] word_index, [47:46] error_code,
  // [63:48] num_channels, [95:64] sample_rate, [127:96] samples_per_channel
  output logic [127:0] m_tdata,
  output logic         m_tuser,   // [0] kind
  output logic         m_tlast
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_DIV_A = 2'd1,
    ST_DIV_B = 2'd2,
    ST_STAT  = 2'd3
  } state_t;

  state_t          state;
  wrsp_pkg::smp_t  smp;
  wrsp_pkg::stat_t stat;
  wrsp_pkg::stat_t st;
  logic [31:0]     spc;
  logic            out_free;
  logic            out_load;
  logic            take;
  logic            div_start;
  logic [31:0]     div_dvd;
  logic [15:0]     div_dvs;
  logic            div_done;
  logic [31:0]     div_q;
  logic [15:0]     stat_bytes;

  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == ST_IDLE) && out_free;
  assign take       = s_tvalid && s_tready;
  assign stat_bytes = {3'b000, stat.bps[15:3]};

  // output register takes a new item this cycle
  assign out_load = ((state == ST_IDLE) && take && smp.valid) ||
                    ((state == ST_STAT) && out_free);

  wrsp_parse #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .final_byte(s_tlast),
    .smp       (smp),
    .stat      (stat)
  );

  // divider operands: first by bytes per sample, then by channels
  always_comb begin
    div_start = 1'b0;
    div_dvd   = stat.dlen;
    div_dvs   = stat_bytes;
    if (state == ST_IDLE) begin
      div_start = take && s_tlast && stat.err == wrsp_pkg::ERR_OK &&
                  stat_bytes != 16'd0 && stat.ch != 16'd0;
    end else if (state == ST_DIV_A) begin
      div_start = div_done;
      div_dvd   = div_q;
      div_dvs   = st.ch;
    end
  end

  wrsp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dvd),
    .divisor (div_dvs),
    .done    (div_done),
    .quotient(div_q)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (smp.valid) begin
              m_tuser  <= wrsp_pkg::KIND_SAMPLE;
              m_tlast  <= 1'b0;
              m_tdata  <= {80'd0, 2'd0, smp.index, smp.value};
            end
            if (s_tlast) begin
              st    <= stat;
              spc   <= '0;
              state <= div_start ? ST_DIV_A : ST_STAT;
            end
          end
        end
        ST_DIV_A: begin
          if (div_done) state <= ST_DIV_B;
        end
        ST_DIV_B: begin
          if (div_done) begin
            spc   <= div_q;
            state <= ST_STAT;
          end
        end
        ST_STAT: begin
          if (out_free) begin
            m_tuser  <= wrsp_pkg::KIND_STATUS;
            m_tlast  <= 1'b1;
            if (st.err == wrsp_pkg::ERR_OK)
              m_tdata <= {spc, st.rate, st.ch, st.err, 30'd0, 16'd0};
            else
              m_tdata <= {80'd0, st.err, 30'd0, 16'd0};
            state <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule
